// ===== rtl/depth_normal_shading_defines.svh =====
// assertion macros shared by the checker
`ifndef DEPTH_NORMAL_SHADING_DEFINES_SVH
`define DEPTH_NORMAL_SHADING_DEFINES_SVH

// same-cycle implication
`define DNS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dns_pkg.sv =====
package dns_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int COORD_BITS_DEF = 16;

    // unit vectors are Q2.14
    localparam int UNIT_FRAC = 14;
    localparam int UNIT_W    = 16;

    // magnitudes are brought below 2^MAG_BITS before squaring
    localparam int MAG_BITS = 30;

    localparam logic [10:0] WIDTH_RESET   = 11'd640;
    localparam logic [12:0] HEIGHT_RESET  = 13'd480;
    localparam logic [15:0] LIGHT_X_RESET = 16'd6689;
    localparam logic [15:0] LIGHT_Y_RESET = 16'd6689;
    localparam logic [15:0] LIGHT_Z_RESET = 16'd13377;

    typedef struct packed {
        logic valid;
        logic blank;
        logic row_end;
        logic frame_end;
    } dns_flags_t;

endpackage

// ===== rtl/depth_normal_shading.sv =====
// depth_normal_shading: grey shading of a raster stream of vertices
//
// vertices enter on the vert channel (valid/ready), one item per pixel in
// raster order; x and y are signed millimetres, z unsigned with 0 = no data.
// one shade item leaves on the shade channel for every interior pixel, with
// row_end and frame_end marking the last interior pixel of a row and frame.
// image size and light direction sit behind an apb port (pready tied high)
// and are to be written only while the block is idle; it does not check this.
// throughput is one item per clock while no result is stalled: the line store
// is read when an item is taken and written back one stage later, and every
// later stage is a register stage. the pipeline depth is set mostly by the
// square-root and divide pipelines inside the five normalizers (four for the
// cross normals, one for the sum normal).
// reset clears counters, window, valid bits and restores default config;
// the line store is not cleared. when shade_ready is low with a result
// waiting, the whole pipeline holds and vert_ready drops; nothing is lost.
module depth_normal_shading #(
    parameter int MAX_WIDTH  = dns_pkg::MAX_WIDTH_DEF,
    parameter int COORD_BITS = dns_pkg::COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        vert_valid,
    output logic        vert_ready,
    input  logic signed [15:0] vert_x,
    input  logic signed [15:0] vert_y,
    input  logic [15:0] vert_z,
    output logic        shade_valid,
    input  logic        shade_ready,
    output logic [7:0]  shade,
    output logic        row_end,
    output logic        frame_end
);
    import dns_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int VW   = 3 * CB;
    localparam int DW   = CB + 1;
    localparam int PW   = 2 * DW;
    localparam int XW   = PW + 1;
    localparam int COLB = $clog2(MAX_WIDTH);
    localparam int WB   = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
    localparam int SUMW = UNIT_W + 2;
    localparam int DPW  = 34;

    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_LIGHT_X = 3'd2;
    localparam logic [2:0] REG_LIGHT_Y = 3'd3;
    localparam logic [2:0] REG_LIGHT_Z = 3'd4;

    // configuration
    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [15:0] light_reg [3];
    logic        cfg_wr;

    // position and pipeline control
    logic [COLB-1:0] column_count_reg;
    logic [11:0]     row_count_reg;
    logic            adv;
    logic            take;

    logic [WB-1:0]   w_c;
    logic [12:0]     h_c;
    logic            wrap_c;
    logic [COLB-1:0] col_c;
    logic [12:0]     row_inc_c;
    logic [11:0]     row_c;
    logic [CB-1:0]   in_x;
    logic [CB-1:0]   in_y;
    logic [CB-1:0]   in_z;

    // line store and window
    logic [2*VW-1:0] line_mem [MAX_WIDTH];
    logic [2*VW-1:0] rd_reg;
    logic            b_valid_reg;
    logic [VW-1:0]   b_vert_reg;
    logic [COLB-1:0] b_col_reg;
    dns_flags_t      b_flags_reg;
    logic [VW-1:0]   win_reg [9];

    dns_flags_t      c_flags_reg;
    dns_flags_t      d_flags_reg;
    dns_flags_t      e_flags_reg;
    dns_flags_t      f_flags_reg;
    dns_flags_t      g_flags_reg;
    dns_flags_t      n2_flags;
    dns_flags_t      h_flags_reg;
    dns_flags_t      i_flags_reg;
    dns_flags_t      m_flags_reg;

    logic signed [DW-1:0]  dd_reg [4][3];
    logic signed [PW-1:0]  pr_reg [4][6];
    logic signed [XW-1:0]  cr_reg [4][3];
    logic [3:0]            n1_tag;
    logic signed [UNIT_W-1:0] nv [4][3];
    logic signed [SUMW-1:0] sg_reg [3];
    logic signed [UNIT_W-1:0] un [3];
    logic signed [31:0]    m_reg [3];
    logic signed [DPW-1:0] dp_reg;
    logic [DPW-1:0]        mag_reg;
    logic [DPW+7:0]        x255;

    logic       shade_valid_reg;
    logic [7:0] shade_reg;
    logic       row_end_reg;
    logic       frame_end_reg;

    function automatic logic signed [DW-1:0] fx(input logic [VW-1:0] v);
        return DW'($signed(v[VW-1:2*CB]));
    endfunction

    function automatic logic signed [DW-1:0] fy(input logic [VW-1:0] v);
        return DW'($signed(v[2*CB-1:CB]));
    endfunction

    function automatic logic signed [DW-1:0] fz(input logic [VW-1:0] v);
        return $signed({1'b0, v[CB-1:0]});
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            light_reg[0]     <= LIGHT_X_RESET;
            light_reg[1]     <= LIGHT_Y_RESET;
            light_reg[2]     <= LIGHT_Z_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_WIDTH:   image_width_reg  <= pwdata[10:0];
                REG_HEIGHT:  image_height_reg <= pwdata[12:0];
                REG_LIGHT_X: light_reg[0]     <= pwdata[15:0];
                REG_LIGHT_Y: light_reg[1]     <= pwdata[15:0];
                REG_LIGHT_Z: light_reg[2]     <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_WIDTH:   prdata = {21'd0, image_width_reg};
            REG_HEIGHT:  prdata = {19'd0, image_height_reg};
            REG_LIGHT_X: prdata = {16'd0, light_reg[0]};
            REG_LIGHT_Y: prdata = {16'd0, light_reg[1]};
            REG_LIGHT_Z: prdata = {16'd0, light_reg[2]};
            default:     prdata = '0;
        endcase
    end

    // ---------------- pipeline handshake ----------------
    // the whole pipeline moves together; it only holds on a stalled result
    assign adv        = !shade_valid_reg || shade_ready;
    assign vert_ready = adv;
    assign take       = vert_valid && adv;

    // ---------------- position tracking ----------------
    if (CB <= 16) begin : g_narrow
        assign in_x = vert_x[CB-1:0];
        assign in_y = vert_y[CB-1:0];
        assign in_z = vert_z[CB-1:0];
    end else begin : g_wide
        assign in_x = {{(CB-16){1'b0}}, vert_x};
        assign in_y = {{(CB-16){1'b0}}, vert_y};
        assign in_z = {{(CB-16){1'b0}}, vert_z};
    end

    always_comb
    begin
        // clamp the programmed size into the supported range
        w_c = WB'(image_width_reg);
        if (w_c < WB'(3))
        begin
            w_c = WB'(3);
        end
        else if (w_c > WB'(MAX_WIDTH))
        begin
            w_c = WB'(MAX_WIDTH);
        end
        h_c = image_height_reg;
        if (h_c < 13'd3)
        begin
            h_c = 13'd3;
        end
        else if (h_c > 13'd4096)
        begin
            h_c = 13'd4096;
        end
        // a column count past a shrunken width ends the row
        wrap_c    = WB'(column_count_reg) >= w_c;
        col_c     = wrap_c ? '0 : column_count_reg;
        row_inc_c = 13'(row_count_reg) + 13'(wrap_c);
        row_c     = (row_inc_c >= h_c) ? '0 : row_inc_c[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (take)
        begin
            if (WB'(col_c) >= w_c - WB'(1))
            begin
                column_count_reg <= '0;
                row_count_reg    <= (13'(row_c) >= h_c - 13'd1) ? '0 : row_c + 12'd1;
            end
            else
            begin
                column_count_reg <= COLB'(col_c + 1'b1);
                row_count_reg    <= row_c;
            end
        end
    end

    // ---------------- line store: read on take, write one stage later ----------------
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_reg <= line_mem[col_c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg)
        begin
            line_mem[b_col_reg] <= {rd_reg[VW-1:0], b_vert_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            b_vert_reg <= {in_x, in_y, in_z};
            b_col_reg  <= col_c;
        end
    end

    // valid and flag bits of every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_flags_reg <= '0;
            c_flags_reg <= '0;
            d_flags_reg <= '0;
            e_flags_reg <= '0;
            f_flags_reg <= '0;
            g_flags_reg <= '0;
            h_flags_reg <= '0;
            i_flags_reg <= '0;
            m_flags_reg <= '0;
            shade_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            b_valid_reg           <= take;
            b_flags_reg.valid     <= row_c >= 12'd2 && col_c >= COLB'(2);
            b_flags_reg.blank     <= 1'b0;
            b_flags_reg.row_end   <= WB'(col_c) == w_c - WB'(1);
            b_flags_reg.frame_end <= WB'(col_c) == w_c - WB'(1) && 13'(row_c) == h_c - 13'd1;
            // window shifts left by one column as each item goes in
            if (b_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[3*r]     <= win_reg[3*r + 1];
                    win_reg[3*r + 1] <= win_reg[3*r + 2];
                end
                win_reg[2] <= rd_reg[2*VW-1:VW];
                win_reg[5] <= rd_reg[VW-1:0];
                win_reg[8] <= b_vert_reg;
            end
            c_flags_reg       <= {b_valid_reg && b_flags_reg.valid, b_flags_reg.blank,
                                  b_flags_reg.row_end, b_flags_reg.frame_end};
            d_flags_reg       <= {c_flags_reg.valid, win_reg[4][CB-1:0] == {CB{1'b0}},
                                  c_flags_reg.row_end, c_flags_reg.frame_end};
            e_flags_reg       <= d_flags_reg;
            f_flags_reg       <= e_flags_reg;
            g_flags_reg       <= {n1_tag[0], n1_tag[1], n1_tag[2], n1_tag[3]};
            h_flags_reg       <= n2_flags;
            i_flags_reg       <= h_flags_reg;
            m_flags_reg       <= i_flags_reg;
            shade_valid_reg   <= m_flags_reg.valid;
        end
    end

    // ---------------- differences, products, cross products ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // diagonal neighbours: top left, top right, bottom right, bottom left
            dd_reg[0][0] <= fx(win_reg[0]) - fx(win_reg[4]);
            dd_reg[0][1] <= fy(win_reg[0]) - fy(win_reg[4]);
            dd_reg[0][2] <= fz(win_reg[0]) - fz(win_reg[4]);
            dd_reg[1][0] <= fx(win_reg[2]) - fx(win_reg[4]);
            dd_reg[1][1] <= fy(win_reg[2]) - fy(win_reg[4]);
            dd_reg[1][2] <= fz(win_reg[2]) - fz(win_reg[4]);
            dd_reg[2][0] <= fx(win_reg[8]) - fx(win_reg[4]);
            dd_reg[2][1] <= fy(win_reg[8]) - fy(win_reg[4]);
            dd_reg[2][2] <= fz(win_reg[8]) - fz(win_reg[4]);
            dd_reg[3][0] <= fx(win_reg[6]) - fx(win_reg[4]);
            dd_reg[3][1] <= fy(win_reg[6]) - fy(win_reg[4]);
            dd_reg[3][2] <= fz(win_reg[6]) - fz(win_reg[4]);
            for (int p = 0; p < 4; p++)
            begin
                pr_reg[p][0] <= PW'(dd_reg[p][1]) * PW'(dd_reg[(p+1)%4][2]);
                pr_reg[p][1] <= PW'(dd_reg[p][2]) * PW'(dd_reg[(p+1)%4][1]);
                pr_reg[p][2] <= PW'(dd_reg[p][2]) * PW'(dd_reg[(p+1)%4][0]);
                pr_reg[p][3] <= PW'(dd_reg[p][0]) * PW'(dd_reg[(p+1)%4][2]);
                pr_reg[p][4] <= PW'(dd_reg[p][0]) * PW'(dd_reg[(p+1)%4][1]);
                pr_reg[p][5] <= PW'(dd_reg[p][1]) * PW'(dd_reg[(p+1)%4][0]);
                cr_reg[p][0] <= XW'(pr_reg[p][0]) - XW'(pr_reg[p][1]);
                cr_reg[p][1] <= XW'(pr_reg[p][2]) - XW'(pr_reg[p][3]);
                cr_reg[p][2] <= XW'(pr_reg[p][4]) - XW'(pr_reg[p][5]);
            end
        end
    end

    // ---------------- four face normals ----------------
    dns_norm #(.IW(XW), .TW(1)) u_norm0 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .tag_in(f_flags_reg.valid), .vec_in(cr_reg[0]),
        .tag_out(n1_tag[0]), .vec_out(nv[0])
    );
    dns_norm #(.IW(XW), .TW(1)) u_norm1 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .tag_in(f_flags_reg.blank), .vec_in(cr_reg[1]),
        .tag_out(n1_tag[1]), .vec_out(nv[1])
    );
    dns_norm #(.IW(XW), .TW(1)) u_norm2 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .tag_in(f_flags_reg.row_end), .vec_in(cr_reg[2]),
        .tag_out(n1_tag[2]), .vec_out(nv[2])
    );
    dns_norm #(.IW(XW), .TW(1)) u_norm3 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .tag_in(f_flags_reg.frame_end), .vec_in(cr_reg[3]),
        .tag_out(n1_tag[3]), .vec_out(nv[3])
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sg_reg[i] <= SUMW'(nv[0][i]) + SUMW'(nv[1][i]) + SUMW'(nv[2][i])
                           + SUMW'(nv[3][i]);
            end
        end
    end

    // ---------------- pixel normal ----------------
    dns_norm #(.IW(SUMW), .TW($bits(dns_flags_t))) u_norm_sum (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .tag_in(g_flags_reg), .vec_in(sg_reg),
        .tag_out(n2_flags), .vec_out(un)
    );

    // ---------------- lighting ----------------
    assign x255 = {mag_reg, 8'd0} - (DPW+8)'(mag_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= 32'(un[i]) * 32'($signed(light_reg[i]));
            end
            dp_reg  <= DPW'(m_reg[0]) + DPW'(m_reg[1]) + DPW'(m_reg[2]);
            mag_reg <= dp_reg[DPW-1] ? DPW'(-dp_reg) : DPW'(dp_reg);
            row_end_reg   <= m_flags_reg.row_end;
            frame_end_reg <= m_flags_reg.frame_end;
            // centre without depth is dark; otherwise |dot| * 255 >> 28, saturated
            if (m_flags_reg.blank)
            begin
                shade_reg <= 8'd0;
            end
            else if (x255[DPW+7:36] != '0)
            begin
                shade_reg <= 8'd255;
            end
            else
            begin
                shade_reg <= x255[35:28];
            end
        end
    end

    assign shade_valid = shade_valid_reg;
    assign shade       = shade_reg;
    assign row_end     = row_end_reg;
    assign frame_end   = frame_end_reg;

endmodule

// ===== rtl/dns_norm.sv =====
module dns_norm #(
    parameter int IW = 35,
    parameter int TW = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [TW-1:0]                     tag_in,
    input  logic signed [IW-1:0]              vec_in [3],
    output logic [TW-1:0]                     tag_out,
    output logic signed [dns_pkg::UNIT_W-1:0] vec_out [3]
);
    import dns_pkg::*;

    localparam int SH  = (IW > MAG_BITS) ? IW - MAG_BITS : 0;
    localparam int SHB = (SH > 0) ? $clog2(SH + 1) : 1;
    localparam int MW  = (IW > MAG_BITS) ? MAG_BITS : IW;
    localparam int SW  = 2 * MW + 2;
    localparam int RW  = MW + 1;
    localparam int RMW = RW + 3;
    localparam int QB  = UNIT_FRAC + 1;
    localparam int LAT = RW + QB + 6;
    localparam int SQ0 = 4;
    localparam int DV0 = RW + 5;

    logic [TW-1:0]       tag_reg   [LAT];
    logic [2:0]          ng_reg    [LAT-1];
    logic [IW-1:0]       a1_reg    [3];
    logic [IW-1:0]       a2_reg    [3];
    logic [SHB-1:0]      sh2_reg;
    logic [SHB-1:0]      sh_next;
    logic [IW-1:0]       mx_next;
    logic [MW-1:0]       mag_reg   [2:RW+4][3];
    logic [2*MW-1:0]     sq_reg    [3];
    logic [SW-1:0]       num_reg   [SQ0:RW+4];
    logic [RMW-1:0]      rem_reg   [SQ0:RW+4];
    logic [RW-1:0]       root_reg  [SQ0:RW+4];
    logic [RW:0]         rdiv_reg  [DV0:LAT-2][3];
    logic [QB-1:0]       q_reg     [DV0:LAT-2][3];
    logic [RW-1:0]       dvs_reg   [DV0:LAT-2];
    logic                zl_reg    [DV0:LAT-2];
    logic signed [UNIT_W-1:0] out_reg [3];

    function automatic logic [RMW+RW-1:0] sqrt_step(input logic [RMW-1:0] rem,
                                                    input logic [RW-1:0] root,
                                                    input logic [1:0] bits);
        logic [RMW-1:0] cand;
        logic [RMW-1:0] test;
        cand = {rem[RMW-3:0], bits};
        test = {1'b0, root, 2'b01};
        if (cand >= test)
        begin
            return {cand - test, root[RW-2:0], 1'b1};
        end
        return {cand, root[RW-2:0], 1'b0};
    endfunction

    // returns the quotient bit above the new remainder
    function automatic logic [RW+1:0] div_step(input logic [RW:0] r, input logic [RW-1:0] d);
        if (r >= {1'b0, d})
        begin
            return {1'b1, r - {1'b0, d}};
        end
        return {1'b0, r};
    endfunction

    assign mx_next = a1_reg[0] | a1_reg[1] | a1_reg[2];

    // smallest shift that brings the largest magnitude below the limit
    if (SH > 0) begin : g_shift
        always_comb
        begin
            sh_next = '0;
            for (int k = 0; k < SH; k++)
            begin
                if (mx_next[MAG_BITS + k])
                begin
                    sh_next = SHB'(k + 1);
                end
            end
        end
    end else begin : g_noshift
        assign sh_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                tag_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int k = 1; k < LAT; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= vec_in[i][IW-1] ? IW'(-vec_in[i]) : IW'(vec_in[i]);
                ng_reg[0][i] <= vec_in[i][IW-1];
            end
            for (int k = 1; k < LAT - 1; k++)
            begin
                ng_reg[k] <= ng_reg[k-1];
            end
            a2_reg  <= a1_reg;
            sh2_reg <= sh_next;
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[2][i] <= MW'(a2_reg[i] >> sh2_reg);
                sq_reg[i] <= (2*MW)'(mag_reg[2][i]) * (2*MW)'(mag_reg[2][i]);
            end
            for (int k = 3; k <= RW + 4; k++)
            begin
                mag_reg[k] <= mag_reg[k-1];
            end
            // integer square root, one result bit per stage
            num_reg[SQ0]  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            rem_reg[SQ0]  <= '0;
            root_reg[SQ0] <= '0;
            for (int k = SQ0 + 1; k <= RW + 4; k++)
            begin
                {rem_reg[k], root_reg[k]} <= sqrt_step(rem_reg[k-1], root_reg[k-1],
                                                       num_reg[k-1][SW-1:SW-2]);
                num_reg[k] <= num_reg[k-1] << 2;
            end
            // magnitude * 2^14 / length, one quotient bit per stage
            dvs_reg[DV0] <= root_reg[RW+4];
            zl_reg[DV0]  <= (root_reg[RW+4] == '0);
            for (int i = 0; i < 3; i++)
            begin
                {q_reg[DV0][i][0], rdiv_reg[DV0][i]} <=
                    div_step((RW+1)'(mag_reg[RW+4][i]), root_reg[RW+4]);
                q_reg[DV0][i][QB-1:1] <= '0;
            end
            for (int j = DV0 + 1; j <= LAT - 2; j++)
            begin
                dvs_reg[j] <= dvs_reg[j-1];
                zl_reg[j]  <= zl_reg[j-1];
                for (int i = 0; i < 3; i++)
                begin
                    {q_reg[j][i][0], rdiv_reg[j][i]} <=
                        div_step({rdiv_reg[j-1][i][RW-1:0], 1'b0}, dvs_reg[j-1]);
                    q_reg[j][i][QB-1:1] <= q_reg[j-1][i][QB-2:0];
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                if (zl_reg[LAT-2])
                begin
                    out_reg[i] <= '0;
                end
                else if (ng_reg[LAT-2][i])
                begin
                    out_reg[i] <= -$signed(UNIT_W'(q_reg[LAT-2][i]));
                end
                else
                begin
                    out_reg[i] <= $signed(UNIT_W'(q_reg[LAT-2][i]));
                end
            end
        end
    end

    assign tag_out = tag_reg[LAT-1];
    assign vec_out = out_reg;

endmodule

// ===== rtl/dns_checker.sv =====
`include "depth_normal_shading_defines.svh"

module dns_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       vert_valid,
    input logic       vert_ready,
    input logic       shade_valid,
    input logic       shade_ready,
    input logic [7:0] shade,
    input logic       row_end,
    input logic       frame_end
);

    // a waiting result must freeze the input side
    `DNS_ASSERT_NOW(a_stall_blocks_input, shade_valid && !shade_ready, !vert_ready, "item taken while result stalled")

    // with no result pending the block takes items
    `DNS_ASSERT_NOW(a_ready_when_empty, !shade_valid, vert_ready, "not ready with empty output")

    // the last pixel of a frame is also the last of its row
    `DNS_ASSERT_NOW(a_frame_end_row_end, shade_valid && frame_end, row_end, "frame end without row end")

    `DNS_ASSERT_NEXT(a_stall_holds, shade_valid && !shade_ready, shade_valid && $stable(shade) && $stable(row_end) && $stable(frame_end), "stalled result changed")

endmodule

bind depth_normal_shading dns_checker u_dns_checker (.*);

// ===== test/depth_normal_shading_test.sv =====
module depth_normal_shading_test;

    import dns_pkg::*;

    // register byte addresses, one 32-bit slot per register
    localparam logic [4:0] ADDR_WIDTH   = 5'd0;
    localparam logic [4:0] ADDR_HEIGHT  = 5'd4;
    localparam logic [4:0] ADDR_LIGHT_X = 5'd8;
    localparam logic [4:0] ADDR_LIGHT_Y = 5'd12;
    localparam logic [4:0] ADDR_LIGHT_Z = 5'd16;

    localparam int LINE_DEPTH   = 1024;
    localparam int DRAIN_CYCLES = 130;   // a bit over the pipeline depth
    localparam int LONG_HOLD    = 600;   // receiver hold-off, well over the pipeline depth

    // frame content styles
    typedef enum int { SURF_PLANE, SURF_NOISE, SURF_HOLES, SURF_EXTREME } surface_t;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } point_t;

    typedef struct {
        logic [7:0] shade;
        logic       row_end;
        logic       frame_end;
    } shade_item_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        vert_valid;
    logic        vert_ready;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic [15:0] vert_z;
    logic        shade_valid;
    logic        shade_ready;
    logic [7:0]  shade;
    logic        row_end;
    logic        frame_end;

    depth_normal_shading u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .vert_valid  (vert_valid),
        .vert_ready  (vert_ready),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .shade_valid (shade_valid),
        .shade_ready (shade_ready),
        .shade       (shade),
        .row_end     (row_end),
        .frame_end   (frame_end)
    );

    // 20 time unit clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // predictor copy of the block state and registers
    point_t      line_rows [2][LINE_DEPTH];
    point_t      win [3][3];
    int unsigned next_col;
    int unsigned next_row;
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic signed [15:0] cfg_lx;
    logic signed [15:0] cfg_ly;
    logic signed [15:0] cfg_lz;

    shade_item_t shade_expected[$];
    int          fail_count;
    int          items_sent;

    // per-frame surface parameters
    int surf_base;
    int surf_dz_col;
    int surf_dz_row;
    int surf_pitch;

    // receiver hold-off handshake between test tasks and the receiver process
    int hold_req;
    int hold_seen;
    int hold_left;
    int run_left;
    bit run_ready;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // scale to Q2.14 unit length; a zero vector stays as it is
    function automatic point_t unit_vec(point_t v);
        longint          c[3];
        longint unsigned a[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        bit              neg[3];
        int              s;
        point_t          r;
        c[0] = v.x;
        c[1] = v.y;
        c[2] = v.z;
        mx = 0;
        sum = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = c[i] < 0;
            a[i] = neg[i] ? longint'(-c[i]) : longint'(c[i]);
            if (a[i] > mx)
                mx = a[i];
        end
        while ((mx >> s) >= (64'd1 << MAG_BITS))
            s++;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = a[i] >> s;
            sum += a[i] * a[i];
        end
        len = root_floor(sum);
        if (len == 0)
            return v;
        for (int i = 0; i < 3; i++)
        begin
            q = (a[i] * (64'd1 << UNIT_FRAC)) / len;
            c[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        r.x = c[0];
        r.y = c[1];
        r.z = c[2];
        return r;
    endfunction

    function automatic point_t diff_vec(point_t a, point_t b);
        point_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic point_t cross_vec(point_t a, point_t b);
        point_t r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    function automatic logic [7:0] window_shade();
        point_t d1, d2, d3, d4, n1, n2, n3, n4, s;
        point_t ctr;
        longint dp;
        longint unsigned mag;
        longint unsigned lum;
        ctr = win[1][1];
        // centre without depth is dark
        if (ctr.z == 0)
            return 8'd0;
        d1 = diff_vec(win[0][0], ctr);
        d2 = diff_vec(win[0][2], ctr);
        d3 = diff_vec(win[2][2], ctr);
        d4 = diff_vec(win[2][0], ctr);
        n1 = unit_vec(cross_vec(d1, d2));
        n2 = unit_vec(cross_vec(d2, d3));
        n3 = unit_vec(cross_vec(d3, d4));
        n4 = unit_vec(cross_vec(d4, d1));
        s.x = n1.x + n2.x + n3.x + n4.x;
        s.y = n1.y + n2.y + n3.y + n4.y;
        s.z = n1.z + n2.z + n3.z + n4.z;
        s = unit_vec(s);
        dp = s.x * longint'(cfg_lx) + s.y * longint'(cfg_ly) + s.z * longint'(cfg_lz);
        mag = dp < 0 ? longint'(-dp) : longint'(dp);
        lum = (mag * 255) >> 28;
        return lum > 255 ? 8'd255 : lum[7:0];
    endfunction

    function automatic int unsigned eff_width();
        if (cfg_width < 3)
            return 3;
        if (cfg_width > LINE_DEPTH)
            return LINE_DEPTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height < 3)
            return 3;
        if (cfg_height > 4096)
            return 4096;
        return cfg_height;
    endfunction

    // advance the predictor by one accepted vertex
    task automatic predict_vertex(logic signed [15:0] x, logic signed [15:0] y,
                                  logic [15:0] z);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        point_t      nv;
        point_t      top;
        point_t      mid;
        shade_item_t res;
        w = eff_width();
        h = eff_height();
        if (next_col >= w)
        begin
            next_col = 0;
            next_row++;
        end
        if (next_row >= h)
            next_row = 0;
        c = next_col;
        r = next_row;
        nv.x = longint'(x);
        nv.y = longint'(y);
        nv.z = longint'({1'b0, z});
        top = line_rows[1][c];
        mid = line_rows[0][c];
        line_rows[1][c] = mid;
        line_rows[0][c] = nv;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = nv;
        if (r >= 2 && c >= 2)
        begin
            res.shade     = window_shade();
            res.row_end   = (c == w - 1);
            res.frame_end = (c == w - 1) && (r == h - 1);
            shade_expected.push_back(res);
        end
        if (c >= w - 1)
        begin
            next_col = 0;
            next_row = (r >= h - 1) ? 0 : r + 1;
        end
        else
            next_col = c + 1;
    endtask

    // ---------------------------------------------------------------
    // bus and stream drivers
    // ---------------------------------------------------------------

    task automatic reg_write(logic [4:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // the register takes the value at this edge
        case (addr)
            ADDR_WIDTH:   cfg_width  = data[10:0];
            ADDR_HEIGHT:  cfg_height = data[12:0];
            ADDR_LIGHT_X: cfg_lx     = data[15:0];
            ADDR_LIGHT_Y: cfg_ly     = data[15:0];
            ADDR_LIGHT_Z: cfg_lz     = data[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_light(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz);
        reg_write(ADDR_LIGHT_X, {16'd0, lx});
        reg_write(ADDR_LIGHT_Y, {16'd0, ly});
        reg_write(ADDR_LIGHT_Z, {16'd0, lz});
    endtask

    task automatic set_size(logic [10:0] w, logic [12:0] h);
        reg_write(ADDR_WIDTH, {21'd0, w});
        reg_write(ADDR_HEIGHT, {19'd0, h});
    endtask

    // gap before the next item: mostly none or short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // offer one vertex and hold it until taken; valid stays up across back-to-back items
    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, int gap);
        if (gap > 0)
        begin
            vert_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vert_valid <= 1'b1;
        vert_x     <= x;
        vert_y     <= y;
        vert_z     <= z;
        do
            @(posedge clk);
        while (!vert_ready);
        predict_vertex(x, y, z);
        items_sent++;
    endtask

    task automatic stop_sending();
        vert_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every expected item has come, then let the pipeline settle
    task automatic drain();
        stop_sending();
        while (shade_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic pick_surface();
        surf_base   = $urandom_range(60000, 200);
        surf_dz_col = $urandom_range(400) - 200;
        surf_dz_row = $urandom_range(400) - 200;
        surf_pitch  = $urandom_range(300, 1);
    endtask

    // vertex content for one pixel of the current frame
    task automatic make_vertex(surface_t kind, int c, int r,
                               output logic [15:0] x, output logic [15:0] y,
                               output logic [15:0] z);
        int zi;
        case (kind)
            SURF_NOISE:
            begin
                x = 16'($urandom);
                y = 16'($urandom);
                z = 16'($urandom);
            end
            SURF_EXTREME:
            begin
                x = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7fff;
                y = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7fff;
                case ($urandom_range(2))
                    0: z = 16'hffff;
                    1: z = 16'h0000;
                    default: z = 16'h0001;
                endcase
            end
            default:
            begin
                x  = 16'((c - 10) * surf_pitch + int'($urandom_range(6)) - 3);
                y  = 16'((r - 10) * surf_pitch + int'($urandom_range(6)) - 3);
                zi = surf_base + c * surf_dz_col + r * surf_dz_row
                   + int'($urandom_range(20)) - 10;
                if (zi < 1)
                    zi = 1;
                if (zi > 65535)
                    zi = 65535;
                z = 16'(zi);
                // missing depth, sometimes on a centre
                if (kind == SURF_HOLES && $urandom_range(5) == 0)
                    z = 16'd0;
            end
        endcase
    endtask

    // one whole frame at the current size
    task automatic send_frame(surface_t kind, bit busy);
        int unsigned w;
        int unsigned h;
        logic [15:0] x, y, z;
        w = eff_width();
        h = eff_height();
        pick_surface();
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                make_vertex(kind, c, r, x, y, z);
                send_vertex(x, y, z, busy ? pick_gap() : 0);
            end
    endtask

    function automatic surface_t pick_kind();
        int p;
        p = $urandom_range(9);
        if (p < 5)
            return SURF_PLANE;
        if (p < 8)
            return SURF_HOLES;
        return SURF_NOISE;
    endfunction

    // ---------------------------------------------------------------
    // receiver: random ready with bursts, short and long stalls, and a long hold on request
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shade_ready <= 1'b0;
        end
        else
        begin
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                shade_ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    case ($urandom_range(9))
                        0, 1, 2, 3:
                        begin
                            run_ready = 1'b1;
                            run_left  = $urandom_range(60, 1);
                        end
                        4, 5, 6, 7, 8:
                        begin
                            run_ready = 1'b0;
                            run_left  = $urandom_range(3, 1);
                        end
                        default:
                        begin
                            run_ready = 1'b0;
                            run_left  = $urandom_range(50, 10);
                        end
                    endcase
                end
                run_left--;
                shade_ready <= run_ready;
            end
        end
    end

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        shade_item_t exp_item;
        if (rst_n && shade_valid && shade_ready)
        begin
            if (shade_expected.size() == 0)
            begin
                $error("shade item with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_item = shade_expected.pop_front();
                if (shade !== exp_item.shade)
                begin
                    $error("shade: expected %0d, got %0d", exp_item.shade, shade);
                    fail_count++;
                end
                if (row_end !== exp_item.row_end)
                begin
                    $error("row_end: expected %0b, got %0b", exp_item.row_end, row_end);
                    fail_count++;
                end
                if (frame_end !== exp_item.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b", exp_item.frame_end, frame_end);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // 3x3 and 4x3 frames with coordinate and depth extremes, light at the unit extremes
    task automatic test_extremes();
        set_size(11'd3, 13'd3);
        set_light(16'd16384, 16'd0, 16'd0);
        send_frame(SURF_EXTREME, 1'b0);
        drain();
        set_light(16'd0, -16'sd16384, 16'd0);
        set_size(11'd4, 13'd3);
        send_frame(SURF_EXTREME, 1'b1);
        drain();
    endtask

    // sizes below the minimum clamp to three
    task automatic test_clamped_sizes();
        set_light(16'd0, 16'd0, 16'd16384);
        set_size(11'd0, 13'd1);
        send_frame(SURF_HOLES, 1'b1);
        drain();
        set_size(11'd2, 13'd0);
        send_frame(SURF_PLANE, 1'b1);
        drain();
        set_size(11'd1, 13'd2);
        send_frame(SURF_NOISE, 1'b1);
        drain();
    endtask

    // light vectors off unit length saturate; every light bit toggles
    task automatic test_light_settings();
        set_size(11'd8, 13'd5);
        set_light(16'h7fff, 16'h7fff, 16'h7fff);
        send_frame(SURF_PLANE, 1'b1);
        drain();
        set_light(16'h8000, 16'h8000, 16'h8000);
        send_frame(SURF_HOLES, 1'b1);
        drain();
        set_light(-16'sd16384, 16'd16384, -16'sd16384);
        send_frame(SURF_NOISE, 1'b1);
        drain();
    endtask

    // long receiver hold while the sender keeps offering: the block fills and stalls
    task automatic test_backpressure();
        set_size(11'd20, 13'd12);
        set_light(16'd6689, -16'sd6689, 16'd13377);
        hold_req++;
        send_frame(SURF_PLANE, 1'b0);
        drain();
    endtask

    // sender stops mid-frame until everything expected has come, then resumes
    task automatic test_sender_pause();
        logic [15:0] x, y, z;
        set_size(11'd10, 13'd6);
        pick_surface();
        for (int r = 0; r < 6; r++)
            for (int c = 0; c < 10; c++)
            begin
                if (r == 3 && c == 5)
                begin
                    stop_sending();
                    while (shade_expected.size() != 0)
                        @(posedge clk);
                end
                make_vertex(SURF_PLANE, c, r, x, y, z);
                send_vertex(x, y, z, pick_gap());
            end
        drain();
    endtask

    // random small frames with occasional size and light changes between frames
    task automatic test_random_frames();
        int goal;
        goal = items_sent + 900;
        while (items_sent < goal)
        begin
            if ($urandom_range(2) == 0)
            begin
                // registers change only with nothing in flight
                drain();
                set_size(11'($urandom_range(24, 3)), 13'($urandom_range(12, 3)));
                if ($urandom_range(1) == 0)
                    set_light(16'($urandom), 16'($urandom), 16'($urandom));
                else
                    set_light(16'(int'($urandom_range(32768)) - 16384),
                              16'(int'($urandom_range(32768)) - 16384),
                              16'(int'($urandom_range(32768)) - 16384));
            end
            send_frame(pick_kind(), $urandom_range(4) != 0);
            if ($urandom_range(3) == 0)
                drain();
        end
        drain();
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        vert_valid = 1'b0;
        vert_x     = '0;
        vert_y     = '0;
        vert_z     = '0;
        fail_count = 0;
        items_sent = 0;
        hold_req   = 0;
        hold_seen  = 0;
        hold_left  = 0;
        run_left   = 0;
        run_ready  = 1'b1;
        next_col   = 0;
        next_row   = 0;
        cfg_width  = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        cfg_lx     = LIGHT_X_RESET;
        cfg_ly     = LIGHT_Y_RESET;
        cfg_lz     = LIGHT_Z_RESET;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < LINE_DEPTH; j++)
                line_rows[i][j] = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '{0, 0, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_clamped_sizes();
        test_light_settings();
        test_backpressure();
        test_sender_pause();
        test_random_frames();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #80000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dns_pkg.sv
rtl/dns_norm.sv
rtl/depth_normal_shading.sv
rtl/dns_checker.sv
test/depth_normal_shading_test.sv
